### hdl/rc4ks_pkg.sv
// ----------------------------------------------------------------------------
// rc4ks_pkg
// shared types for the rc4 keystream cipher: controller commands and
// datapath status
// ----------------------------------------------------------------------------
package rc4ks_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 9;
  localparam logic        CmdKey  = 1'b0;
  localparam logic        CmdData = 1'b1;

  // one command bit per datapath operation
  typedef struct packed {
    logic capture;    // latch the input byte
    logic key_wr;     // store a key byte
    logic sch_start;  // clear schedule counters
    logic init_wr;    // identity fill, one entry
    logic sch_rd;     // schedule: read s[n] and key[k]
    logic sch_j;      // schedule: update j, read s[j]
    logic sch_w1;     // schedule: s[n] = s[j]
    logic sch_w2;     // schedule: s[j] = t, advance n and k
    logic dat_ri;     // data: advance i, read s[i]
    logic dat_rj;     // data: update j, read s[j]
    logic dat_w1;     // data: s[i] = tj, read s[ti + tj]
    logic dat_w2;     // data: s[j] = ti, load result
    logic nokey;      // load a no-key result
  } cmd_t;

  typedef struct packed {
    logic key_ready;
    logic n_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/rc4_keystream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_keystream_cipher_unit
// rc4 stream cipher: key loading, key schedule and keystream xor
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry command_i, byte_in_i and
// last_key_byte_i. a key byte (command 0) is stored when it is taken; bytes
// past MAX_KEY_BYTES are dropped. the key byte flagged last_key_byte_i starts
// the key schedule: an identity fill of all 256 entries of the permutation
// memory, then 256 swap steps, all with in_stall_o high.
// a data byte (command 1) is read, swapped and xored before its result is loaded:
// its three reads and two writes go through the single port pair of the
// permutation memory, so the next byte is taken only once that result is loaded.
// output channel: out_valid_o / out_stall_i carry byte_out_o and no_key_o,
// one transaction per data byte, none per key byte. data before any key
// schedule gives zero with no_key_o set. a stalled result sits in the output
// register while the next item is taken; the block waits only when a second
// result is ready. reset clears indices, key length, key state and the
// output valid; the memories are not cleared.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_unit
  import rc4ks_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_key_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] byte_out_o,
  output logic             no_key_o
);

  cmd_t cmd;
  sts_t sts;

  rc4ks_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .last_key_byte_i (last_key_byte_i),
    .sts_i           (sts),
    .in_stall_o      (in_stall_o),
    .cmd_o           (cmd)
  );

  rc4ks_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .byte_in_i   (byte_in_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .byte_out_o  (byte_out_o),
    .no_key_o    (no_key_o)
  );

endmodule

### hdl/rc4ks_ctrl.sv
// ----------------------------------------------------------------------------
// rc4ks_ctrl
// sequencer for key loading, key schedule and data bytes
// ----------------------------------------------------------------------------
module rc4ks_ctrl
  import rc4ks_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic command_i,
  input  logic last_key_byte_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StSRead = 4'd2;
  localparam logic [3:0] StSJ    = 4'd3;
  localparam logic [3:0] StSW1   = 4'd4;
  localparam logic [3:0] StSW2   = 4'd5;
  localparam logic [3:0] StDRJ   = 4'd6;
  localparam logic [3:0] StDW1   = 4'd7;
  localparam logic [3:0] StDW2   = 4'd8;
  localparam logic [3:0] StNoKey = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (command_i == CmdKey) begin
            cmd_o.key_wr = 1'b1;
            if (last_key_byte_i) begin
              cmd_o.sch_start = 1'b1;
              state_d         = StInit;
            end
          end else if (sts_i.key_ready) begin
            cmd_o.dat_ri = 1'b1;
            state_d      = StDRJ;
          end else begin
            state_d = StNoKey;
          end
        end
      end
      StInit: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.n_last) begin
          state_d = StSRead;
        end
      end
      StSRead: begin
        cmd_o.sch_rd = 1'b1;
        state_d      = StSJ;
      end
      StSJ: begin
        cmd_o.sch_j = 1'b1;
        state_d     = StSW1;
      end
      StSW1: begin
        cmd_o.sch_w1 = 1'b1;
        state_d      = StSW2;
      end
      StSW2: begin
        cmd_o.sch_w2 = 1'b1;
        state_d      = sts_i.n_last ? StIdle : StSRead;
      end
      StDRJ: begin
        cmd_o.dat_rj = 1'b1;
        state_d      = StDW1;
      end
      StDW1: begin
        cmd_o.dat_w1 = 1'b1;
        state_d      = StDW2;
      end
      StDW2: begin
        if (sts_i.out_free) begin
          cmd_o.dat_w2 = 1'b1;
          state_d      = StIdle;
        end
      end
      StNoKey: begin
        if (sts_i.out_free) begin
          cmd_o.nokey = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/rc4ks_datapath.sv
// ----------------------------------------------------------------------------
// rc4ks_datapath
// permutation memory, key store, indices and output register
// ----------------------------------------------------------------------------
module rc4ks_datapath
  import rc4ks_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             out_stall_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  output logic [ByteW-1:0] byte_out_o,
  output logic             no_key_o
);

  localparam int unsigned KeyAw  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_KEY_BYTES);

  logic [ByteW-1:0] perm_mem [256];
  logic [ByteW-1:0] key_mem  [MAX_KEY_BYTES];

  logic [ByteW-1:0] perm_rd_q, key_rd_q;
  logic [ByteW-1:0] byte_q, t_q, tj_q, a_q;
  logic [ByteW-1:0] i_q, j_q, n_q;
  logic [KeyAw-1:0] k_q;
  logic [LenW-1:0]  key_len_q;
  logic             key_ready_q, key_loading_q;
  logic             out_valid_q, no_key_q;
  logic [ByteW-1:0] byte_out_q;

  logic             perm_we, perm_re;
  logic [ByteW-1:0] perm_wa, perm_wd, perm_ra;
  logic [LenW-1:0]  len_base, len_eff;
  logic             key_store_en;
  logic [ByteW-1:0] j_sch, j_dat, ks_byte;

  assign len_base     = key_loading_q ? key_len_q : '0;
  assign key_store_en = cmd_i.key_wr && (len_base < MaxLen);
  assign len_eff      = (key_len_q == '0) ? LenW'(1) : key_len_q;

  assign j_sch = j_q + key_rd_q + perm_rd_q;
  assign j_dat = j_q + perm_rd_q;

  // single write port, single read port on the permutation
  always_comb begin
    perm_we = 1'b0;
    perm_wa = n_q;
    perm_wd = n_q;
    perm_re = 1'b0;
    perm_ra = n_q;
    if (cmd_i.init_wr) begin
      perm_we = 1'b1;
    end else if (cmd_i.sch_rd) begin
      perm_re = 1'b1;
    end else if (cmd_i.sch_j) begin
      perm_re = 1'b1;
      perm_ra = j_sch;
    end else if (cmd_i.sch_w1) begin
      perm_we = 1'b1;
      perm_wd = perm_rd_q;
    end else if (cmd_i.sch_w2) begin
      perm_we = 1'b1;
      perm_wa = j_q;
      perm_wd = t_q;
    end else if (cmd_i.dat_ri) begin
      perm_re = 1'b1;
      perm_ra = i_q + ByteW'(1);
    end else if (cmd_i.dat_rj) begin
      perm_re = 1'b1;
      perm_ra = j_dat;
    end else if (cmd_i.dat_w1) begin
      perm_we = 1'b1;
      perm_wa = i_q;
      perm_wd = perm_rd_q;
      perm_re = 1'b1;
      perm_ra = t_q + perm_rd_q;
    end else if (cmd_i.dat_w2) begin
      perm_we = 1'b1;
      perm_wa = j_q;
      perm_wd = t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    if (perm_re) begin
      perm_rd_q <= perm_mem[perm_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_store_en) begin
      key_mem[len_base[KeyAw-1:0]] <= byte_in_i;
    end
    if (cmd_i.sch_rd) begin
      key_rd_q <= key_mem[k_q];
    end
  end

  // value of s[ti + tj] after the swap: read came before both writes landed
  always_comb begin
    if (a_q == j_q) begin
      ks_byte = t_q;
    end else if (a_q == i_q) begin
      ks_byte = tj_q;
    end else begin
      ks_byte = perm_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= byte_in_i;
    end
    if (cmd_i.sch_j || cmd_i.dat_rj) begin
      t_q <= perm_rd_q;
    end
    if (cmd_i.dat_w1) begin
      tj_q <= perm_rd_q;
      a_q  <= t_q + perm_rd_q;
    end
    if (cmd_i.dat_w2 || cmd_i.nokey) begin
      byte_out_q <= cmd_i.nokey ? '0 : (ks_byte ^ byte_q);
      no_key_q   <= cmd_i.nokey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q           <= '0;
      j_q           <= '0;
      n_q           <= '0;
      k_q           <= '0;
      key_len_q     <= '0;
      key_ready_q   <= 1'b0;
      key_loading_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.key_wr) begin
        key_loading_q <= 1'b1;
        key_len_q     <= key_store_en ? (len_base + LenW'(1)) : len_base;
      end
      if (cmd_i.sch_start) begin
        n_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (cmd_i.init_wr) begin
        n_q <= n_q + ByteW'(1);
      end
      if (cmd_i.sch_j) begin
        j_q <= j_sch;
      end
      if (cmd_i.sch_w2) begin
        n_q <= n_q + ByteW'(1);
        if ((LenW'(k_q) + LenW'(1)) >= len_eff) begin
          k_q <= '0;
        end else begin
          k_q <= k_q + KeyAw'(1);
        end
        if (n_q == '1) begin
          i_q           <= '0;
          j_q           <= '0;
          key_ready_q   <= 1'b1;
          key_loading_q <= 1'b0;
        end
      end
      if (cmd_i.dat_ri) begin
        i_q <= i_q + ByteW'(1);
      end
      if (cmd_i.dat_rj) begin
        j_q <= j_dat;
      end
      if (cmd_i.dat_w2 || cmd_i.nokey) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.key_ready = key_ready_q;
  assign sts_o.n_last    = (n_q == '1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;
  assign no_key_o    = no_key_q;

endmodule
